>>> sv/art_pkg.sv
// Package: shared types and constants of the ACK retransmission tracker.
package art_pkg;

    localparam int QueueDepth = 32;
    localparam int SlotW      = $clog2(QueueDepth);
    localparam int OccW       = SlotW + 1;
    localparam logic [23:0] LingerReset = 24'd200000;
    localparam logic [3:0]  RetryReset  = 4'd3;

    typedef enum logic [2:0] {
        CMD_ENQ   = 3'd0,
        CMD_POP   = 3'd1,
        CMD_ACK   = 3'd2,
        CMD_NAK   = 3'd3,
        CMD_TICK  = 3'd4,
        CMD_CLEAR = 3'd5
    } cmd_t;

    typedef enum logic [2:0] {
        KIND_ENQ  = 3'd0,
        KIND_POP  = 3'd1,
        KIND_MATCH = 3'd2,
        KIND_DONE = 3'd3,
        KIND_END  = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        ST_EMPTY    = 2'd0,
        ST_PENDING  = 2'd1,
        ST_INFLIGHT = 2'd2,
        ST_DONE     = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        OC_OK      = 2'd0,
        OC_TIMEOUT = 2'd1,
        OC_NAK     = 2'd2,
        OC_ABORTED = 2'd3
    } outcome_t;

    localparam logic CFG_LINGER = 1'b0;
    localparam logic CFG_RETRY  = 1'b1;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [7:0]  msg_id;
        logic [15:0] seq;
        logic        ack_req;
        logic        notify;
        logic [23:0] ack_wait_us;
        logic [31:0] now_us;
    } in_word_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic        ok;
        logic [4:0]  slot;
        logic [7:0]  out_msg_id;
        logic [15:0] out_seq;
        logic [1:0]  outcome;
        logic        last;
    } out_word_t;

    typedef struct packed {
        status_t     status;
        logic [7:0]  msg;
        logic [15:0] counter;
        logic        wants_ack;
        logic        notify;
        logic [31:0] deadline;
        logic [3:0]  retries;
        outcome_t    outcome;
    } entry_t;

endpackage

>>> sv/ack_retransmit_tracker_unit.sv
// Top level: ACK retransmission queue with entry memory and walk sequencer.
//
// Input words arrive on in_valid/in_ready/in_data, result words leave on
// out_valid/out_ready/out_data, and registers are written on cfg_valid/
// cfg_ready/cfg_index/cfg_data (index 0 linger_us, 1 retry_limit); cfg_ready
// is always high. Entries live in one 32-entry synchronous memory with a
// registered read. Enqueue is answered directly from idle. Pop, ack, nak,
// tick and clear walk the occupied entries from the head, one entry per
// cycle through the memory read port while the output register is free, and
// pop/ack/nak stop at the first match. Tick and clear give one completion
// word per reported entry and then a walk-end word; the other commands give
// one word. A single output register holds the next word; while it is
// stalled by out_ready the walk holds in place. New input words are taken
// only when no walk is running and the output register is free.
// Reset empties the queue (head and occupancy zero) and restores linger_us to
// 200000 and retry_limit to 3; entry memory contents need no reset because
// only entries below the occupancy are ever read.
module ack_retransmit_tracker_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  art_pkg::in_word_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output art_pkg::out_word_t out_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_index,
    input  logic [23:0]        cfg_data
);
    import art_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_WALK = 3'b010,
        S_FIN  = 3'b100
    } state_t;

    state_t         state_reg, state_next;
    logic [23:0]    linger_reg;
    logic [3:0]     retry_reg;
    logic [SlotW-1:0] head_reg, head_next;
    logic [OccW-1:0]  occ_reg, occ_next;
    logic [SlotW-1:0] idx_reg, idx_next;
    logic [OccW-1:0]  cnt_reg, cnt_next;
    logic           pre_reg, pre_next;
    in_word_t       cmd_reg;
    logic           out_valid_reg, out_valid_next;
    out_word_t      out_data_reg, out_data_next;

    entry_t         mem [QueueDepth];
    entry_t         rdata_reg;
    logic [SlotW-1:0] raddr, waddr;
    logic           we;
    entry_t         wdata;

    logic           free, accept, last_entry, expired;
    logic [31:0]    age;
    logic [SlotW-1:0] cur_slot;
    entry_t         e;

    assign free      = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE) && free;
    assign accept    = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign cur_slot   = head_reg + idx_reg;
    assign last_entry = ({1'b0, idx_reg} + OccW'(1)) == occ_reg;
    assign age        = cmd_reg.now_us - rdata_reg.deadline;
    assign expired    = !age[31];

    // Hold configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            linger_reg <= LingerReset;
            retry_reg  <= RetryReset;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == CFG_LINGER)
                linger_reg <= cfg_data;
            else
                retry_reg <= cfg_data[3:0];
        end
    end

    // Entry memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata_reg <= mem[raddr];
    end

    // Sequence enqueue and the walks
    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        occ_next       = occ_reg;
        idx_next       = idx_reg;
        cnt_next       = cnt_reg;
        pre_next       = pre_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;
        raddr          = head_reg;
        waddr          = cur_slot;
        we             = 1'b0;
        wdata          = rdata_reg;
        e              = rdata_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                idx_next = '0;
                cnt_next = '0;
                pre_next = 1'b1;
                if (accept)
                begin
                    if (in_data.cmd == CMD_ENQ)
                    begin
                        out_valid_next = 1'b1;
                        out_data_next  = '0;
                        out_data_next.kind = KIND_ENQ;
                        out_data_next.last = 1'b1;
                        if (occ_reg < OccW'(QueueDepth))
                        begin
                            waddr = head_reg + occ_reg[SlotW-1:0];
                            we    = 1'b1;
                            wdata.status    = ST_PENDING;
                            wdata.msg       = in_data.msg_id;
                            wdata.counter   = in_data.seq;
                            wdata.wants_ack = in_data.ack_req;
                            wdata.notify    = in_data.notify;
                            wdata.deadline  = in_data.now_us + {8'd0, in_data.ack_req ?
                                              in_data.ack_wait_us : linger_reg};
                            wdata.retries   = '0;
                            wdata.outcome   = OC_OK;
                            occ_next = occ_reg + OccW'(1);
                            out_data_next.ok         = 1'b1;
                            out_data_next.slot       = waddr;
                            out_data_next.out_msg_id = in_data.msg_id;
                            out_data_next.out_seq    = in_data.seq;
                        end
                    end
                    else if (in_data.cmd <= CMD_CLEAR)
                    begin
                        state_next = (occ_reg == '0) ? S_FIN : S_WALK;
                    end
                end
            end

            S_WALK:
            begin
                raddr = cur_slot;
                if (free)
                begin
                    raddr    = cur_slot + SlotW'(1);
                    idx_next = idx_reg + SlotW'(1);
                    if (last_entry)
                        state_next = S_FIN;
                    out_data_next = '0;
                    out_data_next.slot       = cur_slot;
                    out_data_next.out_msg_id = rdata_reg.msg;
                    out_data_next.out_seq    = rdata_reg.counter;
                    case (cmd_reg.cmd)
                        CMD_POP:
                        begin
                            if (rdata_reg.status == ST_PENDING)
                            begin
                                if (rdata_reg.wants_ack)
                                begin
                                    e.status   = ST_INFLIGHT;
                                    e.deadline = cmd_reg.now_us + {8'd0, linger_reg};
                                end
                                else
                                begin
                                    e.status  = ST_DONE;
                                    e.outcome = OC_OK;
                                end
                                we = 1'b1;
                                wdata = e;
                                out_valid_next = 1'b1;
                                out_data_next.kind = KIND_POP;
                                out_data_next.ok   = 1'b1;
                                out_data_next.last = 1'b1;
                                state_next = S_IDLE;
                            end
                        end
                        CMD_ACK, CMD_NAK:
                        begin
                            if (rdata_reg.status == ST_INFLIGHT &&
                                rdata_reg.msg == cmd_reg.msg_id &&
                                rdata_reg.counter == cmd_reg.seq)
                            begin
                                e.status  = ST_DONE;
                                e.outcome = (cmd_reg.cmd == CMD_ACK) ? OC_OK : OC_NAK;
                                we = 1'b1;
                                wdata = e;
                                out_valid_next = 1'b1;
                                out_data_next.kind = KIND_MATCH;
                                out_data_next.ok   = 1'b1;
                                out_data_next.last = 1'b1;
                                state_next = S_IDLE;
                            end
                        end
                        CMD_TICK:
                        begin
                            if (rdata_reg.status == ST_PENDING && expired)
                            begin
                                e.status  = ST_DONE;
                                e.outcome = OC_TIMEOUT;
                            end
                            else if (rdata_reg.status == ST_INFLIGHT && expired)
                            begin
                                if (rdata_reg.retries < retry_reg)
                                begin
                                    e.retries  = rdata_reg.retries + 4'd1;
                                    e.status   = ST_PENDING;
                                    e.deadline = cmd_reg.now_us + {8'd0, linger_reg};
                                end
                                else
                                begin
                                    e.status  = ST_DONE;
                                    e.outcome = OC_TIMEOUT;
                                end
                            end
                            if (e.status == ST_DONE && e.notify)
                            begin
                                e.notify = 1'b0;
                                out_valid_next = 1'b1;
                                out_data_next.kind    = KIND_DONE;
                                out_data_next.ok      = (e.outcome == OC_OK);
                                out_data_next.outcome = e.outcome;
                            end
                            // Count the finished run at the head
                            if (pre_reg && e.status == ST_DONE)
                                cnt_next = cnt_reg + OccW'(1);
                            else
                                pre_next = 1'b0;
                            we = 1'b1;
                            wdata = e;
                        end
                        CMD_CLEAR:
                        begin
                            if (rdata_reg.notify)
                            begin
                                out_valid_next = 1'b1;
                                out_data_next.kind    = KIND_DONE;
                                out_data_next.outcome = OC_ABORTED;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_FIN:
            begin
                if (free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = '0;
                    out_data_next.last = 1'b1;
                    case (cmd_reg.cmd)
                        CMD_POP:          out_data_next.kind = KIND_POP;
                        CMD_ACK, CMD_NAK: out_data_next.kind = KIND_MATCH;
                        default:          out_data_next.kind = KIND_END;
                    endcase
                    if (cmd_reg.cmd == CMD_TICK)
                    begin
                        head_next = head_reg + cnt_reg[SlotW-1:0];
                        occ_next  = occ_reg - cnt_reg;
                    end
                    else if (cmd_reg.cmd == CMD_CLEAR)
                    begin
                        head_next = '0;
                        occ_next  = '0;
                    end
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Advance control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            occ_reg       <= '0;
            idx_reg       <= '0;
            cnt_reg       <= '0;
            pre_reg       <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            occ_reg       <= occ_next;
            idx_reg       <= idx_next;
            cnt_reg       <= cnt_next;
            pre_reg       <= pre_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold payload registers
    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        if (accept)
            cmd_reg <= in_data;
    end

endmodule
